### sv/mmbd_pkg.sv
// ----------------------------------------------------------------------------
// mmbd_pkg
// Shared constants, job descriptor type and sequencer states of the
// min/max bucket decimation block.
// ----------------------------------------------------------------------------
package mmbd_pkg;

	// fixed field widths
	localparam int VAL_W = 32;
	localparam int CNT_W = 6;

	// parameter defaults
	localparam int MAX_POINTS_DEF  = 4096;
	localparam int MAX_BUCKETS_DEF = 32;

	// bucket count after reset
	localparam logic [CNT_W-1:0] CNT_RESET = 6'd32;

	// fixed part of a job descriptor
	typedef struct packed {
		logic             ovf;
		logic [CNT_W-1:0] cnt;
	} job_ctl_t;

	// back end sequencer states
	typedef enum logic [4:0] {
		BK_IDLE,
		BK_DISPATCH,
		BK_RD_FIRST,
		BK_RD_LAST,
		BK_CAP_LAST,
		BK_RANGE,
		BK_BIN_RD,
		BK_BIN_CAP,
		BK_BIN_CMP,
		BK_BIN_DIV,
		BK_BIN_UPD,
		BK_EMIT_END,
		BK_EMIT_CHK,
		BK_EMIT_SEC,
		BK_EMIT_ADV,
		BK_PASS_RD,
		BK_PASS_CAP,
		BK_PUSH,
		BK_FINISH
	} back_state_t;

endpackage

### sv/mmbd_point_if.sv
// ----------------------------------------------------------------------------
// mmbd_point_if
// Input point channel: valid/ready with x, y and the end-of-set mark.
// ----------------------------------------------------------------------------
interface mmbd_point_if;
	import mmbd_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] x_value;
	logic signed [VAL_W-1:0] y_value;
	logic                    last_point;

	modport source (output valid, x_value, y_value, last_point, input ready);
	modport sink   (input valid, x_value, y_value, last_point, output ready);
endinterface

### sv/mmbd_result_if.sv
// ----------------------------------------------------------------------------
// mmbd_result_if
// Result channel: valid/ready with a kept point and its set flags.
// ----------------------------------------------------------------------------
interface mmbd_result_if;
	import mmbd_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] out_x;
	logic signed [VAL_W-1:0] out_y;
	logic                    last_out;
	logic                    overflow;

	modport source (output valid, out_x, out_y, last_out, overflow, input ready);
	modport sink   (input valid, out_x, out_y, last_out, overflow, output ready);
endinterface

### sv/mmbd_ram.sv
// ----------------------------------------------------------------------------
// mmbd_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mmbd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### sv/mmbd_job_queue.sv
// ----------------------------------------------------------------------------
// mmbd_job_queue
// Two-entry queue of closed-set job descriptors between front and back.
// ----------------------------------------------------------------------------
module mmbd_job_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);
	logic [WIDTH-1:0] slot_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       fill_q;

	assign full      = (fill_q == 2'd2);
	assign not_empty = (fill_q != 2'd0);
	assign pop_data  = slot_q[rptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end
endmodule

### sv/mmbd_front.sv
// ----------------------------------------------------------------------------
// mmbd_front
// Point loader: stores each point, tracks fill and overflow, closes a set
// into a job descriptor and holds off input until the job is done.
// ----------------------------------------------------------------------------
module mmbd_front #(
	parameter int MAX_POINTS  = mmbd_pkg::MAX_POINTS_DEF,
	parameter int MAX_BUCKETS = mmbd_pkg::MAX_BUCKETS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	mmbd_point_if.sink                          points,
	input  logic [mmbd_pkg::CNT_W-1:0]          bkt_num,
	output logic                                ram_we,
	output logic [$clog2(MAX_POINTS)-1:0]       ram_waddr,
	output logic [2*mmbd_pkg::VAL_W-1:0]        ram_wdata,
	output logic                                job_push,
	output mmbd_pkg::job_ctl_t                  job_ctl,
	output logic [$clog2(MAX_POINTS+1)-1:0]     job_n,
	input  logic                                job_full,
	input  logic                                job_done
);
	import mmbd_pkg::*;

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic          hold_q;
	logic          xfer;
	logic          stored;

	assign points.ready = !hold_q && !job_full;
	assign xfer         = points.valid && points.ready;
	assign stored       = (count_q < CW'(MAX_POINTS));

	// store write
	assign ram_we    = xfer && stored;
	assign ram_waddr = count_q[IW-1:0];
	assign ram_wdata = {points.x_value, points.y_value};

	// job descriptor at set close
	assign job_push    = xfer && points.last_point;
	assign job_n       = stored ? count_q + CW'(1) : count_q;
	assign job_ctl.ovf = ovf_q || !stored;
	assign job_ctl.cnt = (bkt_num > CNT_W'(MAX_BUCKETS)) ? CNT_W'(MAX_BUCKETS)
		: bkt_num;

	// fill count, overflow and hold until the back end is through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			hold_q  <= 1'b0;
		end else begin
			if (job_done) begin
				hold_q <= 1'b0;
			end
			if (xfer) begin
				if (points.last_point) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
					hold_q  <= 1'b1;
				end else if (stored) begin
					count_q <= count_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end
endmodule

### sv/mmbd_back.sv
// ----------------------------------------------------------------------------
// mmbd_back
// Set processor: pass-through, degenerate range or bucket min/max pass
// over the stored points, then emission through an output register.
// ----------------------------------------------------------------------------
module mmbd_back #(
	parameter int MAX_POINTS  = mmbd_pkg::MAX_POINTS_DEF,
	parameter int MAX_BUCKETS = mmbd_pkg::MAX_BUCKETS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                job_valid,
	input  mmbd_pkg::job_ctl_t                  job_ctl,
	input  logic [$clog2(MAX_POINTS+1)-1:0]     job_n,
	output logic                                job_pop,
	output logic                                job_done,
	output logic                                ram_re,
	output logic [$clog2(MAX_POINTS)-1:0]       ram_raddr,
	input  logic [2*mmbd_pkg::VAL_W-1:0]        ram_rdata,
	mmbd_result_if.source                       results
);
	import mmbd_pkg::*;

	localparam int IW    = $clog2(MAX_POINTS);
	localparam int CW    = $clog2(MAX_POINTS + 1);
	localparam int BW    = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int SW    = (BW > 1) ? $clog2(BW) : 1;
	localparam int NUM_W = VAL_W + CNT_W;
	localparam int CMP_W = (CW > CNT_W + 1) ? CW : CNT_W + 1;

	back_state_t state_q, state_d, ret_q;

	// job
	logic [CW-1:0]    n_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic [IW-1:0]    idx_q;
	logic [IW-1:0]    last_idx;

	// range and binning datapath
	logic [VAL_W-1:0] first_x_q, first_y_q, last_x_q, last_y_q;
	logic [VAL_W-1:0] range_q;
	logic [NUM_W-1:0] rc_q, num_q, rem_q, div_q;
	logic [VAL_W-1:0] px_q, py_q;
	logic             neg_q;
	logic [BW-1:0]    q_q, bsel_q, top_q;
	logic [SW-1:0]    step_q;
	logic [BW:0]      eb_q;

	// bucket tables
	logic [MAX_BUCKETS-1:0] filled_q;
	logic [VAL_W-1:0] lo_y_q [MAX_BUCKETS];
	logic [VAL_W-1:0] lo_x_q [MAX_BUCKETS];
	logic [IW-1:0]    lo_i_q [MAX_BUCKETS];
	logic [VAL_W-1:0] hi_y_q [MAX_BUCKETS];
	logic [VAL_W-1:0] hi_x_q [MAX_BUCKETS];
	logic [IW-1:0]    hi_i_q [MAX_BUCKETS];

	// pending result and output register
	logic [VAL_W-1:0] pend_x_q, pend_y_q;
	logic             pend_last_q;
	logic             out_v_q;
	logic [VAL_W-1:0] out_x_q, out_y_q;
	logic             out_last_q, out_ovf_q;

	logic [VAL_W-1:0] rd_x, rd_y;
	logic [VAL_W:0]   dx;
	logic             ge;
	logic [BW:0]      q_sh;
	logic [BW-1:0]    eidx;
	logic             lo_first, same, out_free, small_set;

	assign rd_x      = ram_rdata[2*VAL_W-1:VAL_W];
	assign rd_y      = ram_rdata[VAL_W-1:0];
	assign last_idx  = IW'(n_q - CW'(1));
	assign dx        = $signed({rd_x[VAL_W-1], rd_x}) - $signed({first_x_q[VAL_W-1], first_x_q});
	assign ge        = (rem_q >= div_q);
	assign q_sh      = {q_q, ge};
	assign eidx      = eb_q[BW-1:0];
	assign lo_first  = (lo_i_q[eidx] <= hi_i_q[eidx]);
	assign same      = (lo_i_q[eidx] == hi_i_q[eidx]);
	assign out_free  = !out_v_q || results.ready;
	assign small_set = (CMP_W'(n_q) <= CMP_W'({cnt_q, 1'b0}));

	assign results.valid    = out_v_q;
	assign results.out_x    = out_x_q;
	assign results.out_y    = out_y_q;
	assign results.last_out = out_last_q;
	assign results.overflow = out_ovf_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, read port and queue control
	always_comb begin
		state_d   = state_q;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		job_pop   = 1'b0;
		job_done  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = BK_DISPATCH;
				end
			end
			BK_DISPATCH: begin
				priority if (cnt_q == '0) state_d = BK_FINISH;
				else if (small_set) state_d = BK_PASS_RD;
				else state_d = BK_RD_FIRST;
			end
			BK_RD_FIRST: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
				state_d   = BK_RD_LAST;
			end
			BK_RD_LAST: begin
				ram_re    = 1'b1;
				ram_raddr = last_idx;
				state_d   = BK_CAP_LAST;
			end
			BK_CAP_LAST: begin
				if ($signed(rd_x) <= $signed(first_x_q)) state_d = BK_PUSH;
				else state_d = BK_RANGE;
			end
			BK_RANGE:   state_d = BK_BIN_RD;
			BK_BIN_RD: begin
				ram_re  = 1'b1;
				state_d = BK_BIN_CAP;
			end
			BK_BIN_CAP: state_d = BK_BIN_CMP;
			BK_BIN_CMP: begin
				if (neg_q || num_q >= rc_q) state_d = BK_BIN_UPD;
				else state_d = BK_BIN_DIV;
			end
			BK_BIN_DIV: begin
				if (step_q == '0) state_d = BK_BIN_UPD;
			end
			BK_BIN_UPD: begin
				if (idx_q == last_idx) state_d = BK_EMIT_CHK;
				else state_d = BK_BIN_RD;
			end
			BK_EMIT_END: state_d = BK_PUSH;
			BK_EMIT_CHK: begin
				priority if (CNT_W'(eb_q) == cnt_q) state_d = BK_FINISH;
				else if (!filled_q[eidx]) state_d = BK_EMIT_ADV;
				else state_d = BK_PUSH;
			end
			BK_EMIT_SEC: state_d = BK_PUSH;
			BK_EMIT_ADV: state_d = BK_EMIT_CHK;
			BK_PASS_RD: begin
				ram_re  = 1'b1;
				state_d = BK_PASS_CAP;
			end
			BK_PASS_CAP: state_d = BK_PUSH;
			BK_PUSH: begin
				if (out_free) state_d = ret_q;
			end
			BK_FINISH: begin
				job_done = 1'b1;
				state_d  = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// control registers: bucket valid bits and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (results.ready) begin
				out_v_q <= 1'b0;
			end
			if (state_q == BK_PUSH && out_free) begin
				out_v_q <= 1'b1;
			end
			if (state_q == BK_CAP_LAST) begin
				filled_q <= '0;
			end
			if (state_q == BK_BIN_UPD) begin
				filled_q[bsel_q] <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				n_q   <= job_n;
				cnt_q <= job_ctl.cnt;
				ovf_q <= job_ctl.ovf;
				idx_q <= '0;
			end
			BK_RD_LAST: begin
				first_x_q <= rd_x;
				first_y_q <= rd_y;
			end
			BK_CAP_LAST: begin
				last_x_q    <= rd_x;
				last_y_q    <= rd_y;
				range_q     <= rd_x - first_x_q;
				pend_x_q    <= first_x_q;
				pend_y_q    <= first_y_q;
				pend_last_q <= 1'b0;
				ret_q       <= BK_EMIT_END;
				idx_q       <= '0;
				top_q       <= '0;
			end
			BK_RANGE: rc_q <= range_q * cnt_q;
			BK_BIN_CAP: begin
				px_q  <= rd_x;
				py_q  <= rd_y;
				neg_q <= dx[VAL_W];
				num_q <= dx[VAL_W-1:0] * cnt_q;
			end
			BK_BIN_CMP: begin
				// below the first x goes low, at or past the range clamps high
				priority if (neg_q) bsel_q <= '0;
				else if (num_q >= rc_q) bsel_q <= BW'(cnt_q - CNT_W'(1));
				else begin
					rem_q  <= num_q;
					div_q  <= NUM_W'(range_q) << (BW - 1);
					step_q <= SW'(BW - 1);
					q_q    <= '0;
				end
			end
			BK_BIN_DIV: begin
				// one quotient bit per cycle
				if (ge) rem_q <= rem_q - div_q;
				div_q  <= div_q >> 1;
				q_q    <= q_sh[BW-1:0];
				bsel_q <= q_sh[BW-1:0];
				step_q <= step_q - SW'(1);
			end
			BK_BIN_UPD: begin
				if (!filled_q[bsel_q]) begin
					lo_y_q[bsel_q] <= py_q;
					lo_x_q[bsel_q] <= px_q;
					lo_i_q[bsel_q] <= idx_q;
					hi_y_q[bsel_q] <= py_q;
					hi_x_q[bsel_q] <= px_q;
					hi_i_q[bsel_q] <= idx_q;
				end else begin
					if ($signed(py_q) < $signed(lo_y_q[bsel_q])) begin
						lo_y_q[bsel_q] <= py_q;
						lo_x_q[bsel_q] <= px_q;
						lo_i_q[bsel_q] <= idx_q;
					end
					if ($signed(py_q) > $signed(hi_y_q[bsel_q])) begin
						hi_y_q[bsel_q] <= py_q;
						hi_x_q[bsel_q] <= px_q;
						hi_i_q[bsel_q] <= idx_q;
					end
				end
				if (bsel_q > top_q) top_q <= bsel_q;
				idx_q <= idx_q + IW'(1);
				eb_q  <= '0;
			end
			BK_EMIT_END: begin
				pend_x_q    <= last_x_q;
				pend_y_q    <= last_y_q;
				pend_last_q <= 1'b1;
				ret_q       <= BK_FINISH;
			end
			BK_EMIT_CHK: begin
				// first of the pair in original order
				pend_x_q    <= lo_first ? lo_x_q[eidx] : hi_x_q[eidx];
				pend_y_q    <= lo_first ? lo_y_q[eidx] : hi_y_q[eidx];
				pend_last_q <= (eidx == top_q) && same;
				ret_q       <= same ? BK_EMIT_ADV : BK_EMIT_SEC;
			end
			BK_EMIT_SEC: begin
				pend_x_q    <= lo_first ? hi_x_q[eidx] : lo_x_q[eidx];
				pend_y_q    <= lo_first ? hi_y_q[eidx] : lo_y_q[eidx];
				pend_last_q <= (eidx == top_q);
				ret_q       <= BK_EMIT_ADV;
			end
			BK_EMIT_ADV: eb_q <= eb_q + (BW+1)'(1);
			BK_PASS_CAP: begin
				pend_x_q    <= rd_x;
				pend_y_q    <= rd_y;
				pend_last_q <= (idx_q == last_idx);
				ret_q       <= (idx_q == last_idx) ? BK_FINISH : BK_PASS_RD;
				idx_q       <= idx_q + IW'(1);
			end
			BK_PUSH: begin
				if (out_free) begin
					out_x_q    <= pend_x_q;
					out_y_q    <= pend_y_q;
					out_last_q <= pend_last_q;
					out_ovf_q  <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

### sv/min_max_bucket_decimation_core.sv
// ----------------------------------------------------------------------------
// min_max_bucket_decimation_core
// Min/max bucket decimation of (x, y) point sets, Q16.16 signed.
// ----------------------------------------------------------------------------
// Usage
//   points  : valid/ready input, one (x, y) per transfer, last_point closes
//             the set. Points load at one per cycle into the point store while input is not held off.
//   results : valid/ready output of kept points; last_out marks the final
//             one of a set, overflow flags points dropped at a full store.
//   cfg_wr_en / cfg_wr_data : bucket count, written while idle.
// Sequence
//   After the closing transfer input is held off while the set is worked:
//   pass-through sets read and push each point in turn; sets whose last x
//   is not above the first give the first and last point; bucketed sets
//   read each point, find its bucket index with a bit-serial divider and
//   update that bucket's min and max, then emit each filled bucket in
//   order. Sets that give nothing finish without reading the store.
// Reset clears the fill count, job queue and bucket valid bits; the bucket
// count returns to 32. A stalled receiver holds the output register and
// the set processor waits; point loading resumes once the set is done.
// ----------------------------------------------------------------------------
module min_max_bucket_decimation_core #(
	parameter int MAX_POINTS  = mmbd_pkg::MAX_POINTS_DEF,
	parameter int MAX_BUCKETS = mmbd_pkg::MAX_BUCKETS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	mmbd_point_if.sink                 points,
	mmbd_result_if.source              results,
	input  logic                       cfg_wr_en,
	input  logic [mmbd_pkg::CNT_W-1:0] cfg_wr_data
);
	import mmbd_pkg::*;

	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int JW = $bits(job_ctl_t) + CW;

	logic [CNT_W-1:0]   bkt_num_q;
	logic               ram_we, ram_re;
	logic [IW-1:0]      ram_waddr, ram_raddr;
	logic [2*VAL_W-1:0] ram_wdata, ram_rdata;
	logic               job_push, job_full, job_pop, job_valid, job_done;
	job_ctl_t           push_ctl, pop_ctl;
	logic [CW-1:0]      push_n, pop_n;
	logic [JW-1:0]      pop_data;

	// bucket count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bkt_num_q <= CNT_RESET;
		end else if (cfg_wr_en) begin
			bkt_num_q <= cfg_wr_data;
		end
	end

	mmbd_front #(.MAX_POINTS(MAX_POINTS), .MAX_BUCKETS(MAX_BUCKETS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.points       (points),
		.bkt_num      (bkt_num_q),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.job_push     (job_push),
		.job_ctl      (push_ctl),
		.job_n        (push_n),
		.job_full     (job_full),
		.job_done     (job_done)
	);

	mmbd_ram #(.WIDTH(2 * VAL_W), .DEPTH(MAX_POINTS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mmbd_job_queue #(.WIDTH(JW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data ({push_ctl, push_n}),
		.full      (job_full),
		.pop       (job_pop),
		.pop_data  (pop_data),
		.not_empty (job_valid)
	);

	assign pop_ctl = pop_data[JW-1:CW];
	assign pop_n   = pop_data[CW-1:0];

	mmbd_back #(.MAX_POINTS(MAX_POINTS), .MAX_BUCKETS(MAX_BUCKETS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ctl   (pop_ctl),
		.job_n     (pop_n),
		.job_pop   (job_pop),
		.job_done  (job_done),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.results   (results)
	);

	// store is never written while the set processor reads it
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("point store written during set processing");

	// job queue never pushed when full
	a_queue_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("job queue overrun");

	// input held off right after a set closes
	a_hold_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		(points.valid && points.ready && points.last_point) |=> !points.ready)
		else $error("input not held off after set close");
endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the min/max bucket decimation core. Point sets go
// in over the valid/ready channel. A behavioural predictor works out the
// kept points of each set when its closing point transfers, and a monitor
// checks every result transfer against them in order. Both channels idle at
// random. Bucket count settings are changed between sets.
// ----------------------------------------------------------------------------
module tb_top;
	import mmbd_pkg::*;

	localparam int MAX_PTS  = 4096;
	localparam int MAX_BKT  = 32;
	localparam int OUT_CAP  = 64;
	localparam int SETTLE   = 16;
	localparam int HOLD_LEN = 400;

	typedef enum logic [1:0] {OP_POINT, OP_DRAIN, OP_CFG} op_t;

	typedef struct {
		op_t              op;
		int               x;
		int               y;
		bit               last;
		logic [CNT_W-1:0] cnt;
	} stim_t;

	typedef struct {
		int x;
		int y;
		bit last;
		bit ovf;
	} kept_pt_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CNT_W-1:0] cfg_wr_data;

	mmbd_point_if  points ();
	mmbd_result_if results ();

	min_max_bucket_decimation_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.points      (points),
		.results     (results),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	stim_t    pending[$];
	kept_pt_t kept_q[$];
	int       fails;
	int       points_sent;
	bit       stim_done;

	// predictor state
	int               set_x[$];
	int               set_y[$];
	bit               set_ovf;
	logic [CNT_W-1:0] bucket_cfg;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// gap length: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// one kept point into the expected results
	function automatic void keep_point(int x, int y, ref int n_out);
		kept_pt_t k;
		if (n_out >= OUT_CAP) return;
		k.x = x;
		k.y = y;
		k.last = 1'b0;
		k.ovf = set_ovf;
		kept_q.push_back(k);
		n_out++;
	endfunction

	// decimate the stored set into kept points
	function automatic void close_set();
		int n, nb, n_out, b;
		longint first, range, dx, q;
		bit fill[MAX_BKT];
		int lo_y[MAX_BKT], lo_x[MAX_BKT], lo_i[MAX_BKT];
		int hi_y[MAX_BKT], hi_x[MAX_BKT], hi_i[MAX_BKT];
		n = set_x.size();
		nb = (bucket_cfg > MAX_BKT) ? MAX_BKT : int'(bucket_cfg);
		n_out = 0;
		if (nb != 0 && n != 0) begin
			if (n <= 2 * nb) begin
				for (int i = 0; i < n; i++) keep_point(set_x[i], set_y[i], n_out);
			end else if (set_x[n-1] <= set_x[0]) begin
				keep_point(set_x[0], set_y[0], n_out);
				keep_point(set_x[n-1], set_y[n-1], n_out);
			end else begin
				first = set_x[0];
				range = longint'(set_x[n-1]) - first;
				for (int i = 0; i < MAX_BKT; i++) fill[i] = 1'b0;
				for (int i = 0; i < n; i++) begin
					dx = longint'(set_x[i]) - first;
					q = (dx < 0) ? 0 : (dx * nb) / range;
					b = (q >= nb) ? nb - 1 : int'(q);
					if (!fill[b]) begin
						fill[b] = 1'b1;
						lo_y[b] = set_y[i]; lo_x[b] = set_x[i]; lo_i[b] = i;
						hi_y[b] = set_y[i]; hi_x[b] = set_x[i]; hi_i[b] = i;
					end else begin
						if (set_y[i] < lo_y[b]) begin
							lo_y[b] = set_y[i]; lo_x[b] = set_x[i]; lo_i[b] = i;
						end
						if (set_y[i] > hi_y[b]) begin
							hi_y[b] = set_y[i]; hi_x[b] = set_x[i]; hi_i[b] = i;
						end
					end
				end
				for (int i = 0; i < nb; i++) begin
					if (!fill[i]) continue;
					if (lo_i[i] <= hi_i[i]) begin
						keep_point(lo_x[i], lo_y[i], n_out);
						if (lo_i[i] != hi_i[i]) keep_point(hi_x[i], hi_y[i], n_out);
					end else begin
						keep_point(hi_x[i], hi_y[i], n_out);
						keep_point(lo_x[i], lo_y[i], n_out);
					end
				end
			end
		end
		if (n_out > 0) kept_q[kept_q.size()-1].last = 1'b1;
		set_x.delete();
		set_y.delete();
		set_ovf = 1'b0;
	endfunction

	// store one accepted point, close the set on its last point
	function automatic void take_point(int x, int y, bit last);
		if (set_x.size() < MAX_PTS) begin
			set_x.push_back(x);
			set_y.push_back(y);
		end else begin
			set_ovf = 1'b1;
		end
		if (last) close_set();
	endfunction

	// driver
	stim_t cur;
	bit    in_flight;
	int    send_gap;
	int    settle;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points.valid <= 1'b0;
			points.x_value <= '0;
			points.y_value <= '0;
			points.last_point <= 1'b0;
			cfg_wr_en <= 1'b0;
			cfg_wr_data <= '0;
			stim_done <= 1'b0;
			in_flight = 1'b0;
			send_gap = 0;
			settle = 0;
			set_ovf = 1'b0;
			bucket_cfg = CNT_RESET;
			points_sent = 0;
		end else begin
			logic wr_n;
			wr_n = 1'b0;
			// accepted transfer goes into the predictor
			if (points.valid && points.ready) begin
				take_point(cur.x, cur.y, cur.last);
				points_sent++;
				in_flight = 1'b0;
				send_gap = pick_gap();
			end
			if (!in_flight) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending.size() > 0) begin
					if (pending[0].op == OP_POINT) begin
						cur = pending.pop_front();
						in_flight = 1'b1;
						points.x_value <= cur.x;
						points.y_value <= cur.y;
						points.last_point <= cur.last;
					end else if (kept_q.size() == 0) begin
						// block idle once all results are back and it has settled
						settle++;
						if (settle >= SETTLE) begin
							settle = 0;
							if (pending[0].op == OP_CFG) begin
								wr_n = 1'b1;
								cfg_wr_data <= pending[0].cnt;
								bucket_cfg = pending[0].cnt;
							end
							void'(pending.pop_front());
						end
					end else begin
						settle = 0;
					end
				end
			end
			points.valid <= in_flight;
			cfg_wr_en <= wr_n;
			stim_done <= (pending.size() == 0) && !in_flight;
		end
	end

	// long receiver hold-off, once
	bit hold_active;
	bit hold_done;
	int hold_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_active <= 1'b0;
			hold_done <= 1'b0;
			hold_left <= 0;
		end else if (!hold_done && !hold_active && points_sent >= 120) begin
			hold_active <= 1'b1;
			hold_left <= HOLD_LEN;
		end else if (hold_active) begin
			if (hold_left == 0) begin
				hold_active <= 1'b0;
				hold_done <= 1'b1;
			end else begin
				hold_left <= hold_left - 1;
			end
		end
	end

	// monitor: check each result transfer against the oldest kept point
	int recv_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
			recv_gap = 0;
			fails = 0;
		end else begin
			if (results.valid && results.ready) begin
				if (kept_q.size() == 0) begin
					$error("unexpected result x=%0d y=%0d", results.out_x, results.out_y);
					fails++;
				end else begin
					kept_pt_t e;
					e = kept_q.pop_front();
					if (results.out_x !== e.x) begin
						$error("out_x: expected %0d, got %0d", e.x, results.out_x);
						fails++;
					end
					if (results.out_y !== e.y) begin
						$error("out_y: expected %0d, got %0d", e.y, results.out_y);
						fails++;
					end
					if (results.last_out !== e.last) begin
						$error("last_out: expected %0d, got %0d", e.last, results.last_out);
						fails++;
					end
					if (results.overflow !== e.ovf) begin
						$error("overflow: expected %0d, got %0d", e.ovf, results.overflow);
						fails++;
					end
				end
				recv_gap = pick_gap();
			end else if (recv_gap > 0) begin
				recv_gap--;
			end
			results.ready <= !hold_active && recv_gap == 0;
		end
	end

	// stimulus builders
	task automatic add_point(int x, int y, bit last);
		stim_t s;
		s.op = OP_POINT; s.x = x; s.y = y; s.last = last; s.cnt = '0;
		pending.push_back(s);
	endtask

	task automatic add_marker(op_t op, logic [CNT_W-1:0] cnt);
		stim_t s;
		s.op = op; s.x = 0; s.y = 0; s.last = 1'b0; s.cnt = cnt;
		pending.push_back(s);
	endtask

	// shape: 0 sorted full range, 1 small steps, 2 flat x,
	// 3 last x not above first, 4 dips below first x
	task automatic add_set(int n, int shape, int yspan);
		int xs[$];
		longint acc;
		int y;
		acc = $signed($urandom_range(32'h7fff_ffff)) - 64'sh4000_0000;
		for (int i = 0; i < n; i++) begin
			case (shape)
				0: xs.push_back(int'($urandom));
				1: begin
					xs.push_back(int'(acc));
					acc += $urandom_range(32'h3_0000);
				end
				default: xs.push_back(int'(acc));
			endcase
		end
		if (shape == 0) xs.sort();
		if (shape == 4) begin
			xs.delete();
			for (int i = 0; i < n; i++) xs.push_back(int'(acc) + i * 1000);
			for (int i = 1; i < n - 1; i += 3) xs[i] = xs[0] - $urandom_range(5000, 1);
		end
		if (shape == 3 && n > 1) xs[n-1] = xs[0] - $urandom_range(5);
		for (int i = 0; i < n; i++) begin
			y = (yspan == 0) ? int'($urandom) : $urandom_range(yspan) - yspan / 2;
			add_point(xs[i], y, i == n - 1);
		end
	endtask

	initial begin
		int items, nb, n;
		logic [CNT_W-1:0] cfgs[10];
		cfgs = '{6'd0, 6'd63, 6'd1, 6'd2, 6'd3, 6'd5, 6'd8, 6'd17, 6'd32, 6'd40};

		// directed: extremes through pass-through at the reset count
		add_point(32'sh7fff_ffff, 32'sh8000_0000, 1'b1);
		add_point(32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
		add_point(0, 0, 1'b1);
		add_marker(OP_CFG, 6'd1);
		// one bucket: flat x gives first and last
		add_point(100, 5, 1'b0); add_point(100, -5, 1'b0); add_point(100, 7, 1'b1);
		// full x span, max before min, ties keep the first
		add_point(32'sh8000_0000, 3, 1'b0); add_point(0, 9, 1'b0);
		add_point(10, 9, 1'b0); add_point(20, -4, 1'b0);
		add_point(32'sh7fff_ffff, -4, 1'b1);
		// one point is both min and max
		add_point(0, 1, 1'b0); add_point(5, 1, 1'b0); add_point(9, 1, 1'b1);
		// x below first goes to bucket zero
		add_point(50, 0, 1'b0); add_point(10, 8, 1'b0); add_point(60, -8, 1'b1);
		add_marker(OP_CFG, 6'd0);
		add_point(1, 2, 1'b0); add_point(3, 4, 1'b1);
		add_marker(OP_DRAIN, '0);
		items = 21;

		// random sets over several bucket counts
		while (items < 300) begin
			add_marker(OP_CFG, cfgs[$urandom_range(9)]);
			nb = (pending[pending.size()-1].cnt > MAX_BKT) ? MAX_BKT
				: int'(pending[pending.size()-1].cnt);
			repeat ($urandom_range(6, 3)) begin
				if (items >= 300) break;
				n = $urandom_range((nb < 4) ? 16 : 2 * nb + 12, 1);
				add_set(n, $urandom_range(4), ($urandom_range(1)) ? 0 : 8);
				items += n;
				if ($urandom_range(3) == 0) add_marker(OP_DRAIN, '0);
			end
		end

		// closing pass-through set at the reset count
		add_marker(OP_CFG, 6'd32);
		add_set(5, 1, 0);
	end

	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		wait (stim_done && kept_q.size() == 0);
		repeat (200) @(posedge clk);
		if (fails == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#60_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

### min_max_bucket_decimation_core.f
sv/mmbd_pkg.sv
sv/mmbd_point_if.sv
sv/mmbd_result_if.sv
sv/mmbd_ram.sv
sv/mmbd_job_queue.sv
sv/mmbd_front.sv
sv/mmbd_back.sv
sv/min_max_bucket_decimation_core.sv
tb/tb_top.sv
